>>> hw/rtl/multi_stack_shared_store_macros.svh
// ----------------------------------------------------------------------------
// multi_stack_shared_store assertion macros
// clocked property helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef MULTI_STACK_SHARED_STORE_MACROS_SVH
`define MULTI_STACK_SHARED_STORE_MACROS_SVH

// same-cycle implication
`define MSSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MSSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/msss_pkg.sv
// ----------------------------------------------------------------------------
// msss_pkg
// operation and status codes of the shared-store stack block
// ----------------------------------------------------------------------------
package msss_pkg;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

>>> hw/rtl/msss_link_mem.sv
// ----------------------------------------------------------------------------
// msss_link_mem
// link memory, one read and one write port, registered read; entries at or above
// the fill mark read as their reset chain value (index plus one)
// ----------------------------------------------------------------------------
module msss_link_mem #(
   parameter int CAPACITY = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [$clog2(CAPACITY)-1:0]    rd_addr,
   output logic [$clog2(CAPACITY+1)-1:0]  rd_data,
   input  logic                           wr_en,
   input  logic [$clog2(CAPACITY)-1:0]    wr_addr,
   input  logic [$clog2(CAPACITY+1)-1:0]  wr_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);

   logic [LW-1:0] mem [CAPACITY];
   logic [LW-1:0] mem_q_ff;
   logic [IW-1:0] addr_q_ff;
   logic          fresh_ff;
   logic [LW-1:0] fill_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff  <= mem[rd_addr];
         addr_q_ff <= rd_addr;
         fresh_ff  <= (LW'(rd_addr) >= fill_ff);
      end
   end

   // length of the run of entries from index zero that have been written in turn
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (wr_en && (LW'(wr_addr) == fill_ff)) begin
         fill_ff <= fill_ff + LW'(1);
      end
   end

   assign rd_data = fresh_ff ? (LW'(addr_q_ff) + LW'(1)) : mem_q_ff;

endmodule

>>> hw/rtl/multi_stack_shared_store.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_store
// several lifo stacks chained through one shared value store and link store
// ----------------------------------------------------------------------------
// the result strobe is registered from the exec state entered at the accepting edge
// a new request is not taken while busy in the exec state, which waits for the link
//    memory read that must return before the stack and free heads can be updated
// results cannot be stalled; a full or empty error leaves all state unchanged
// reset: synchronous, all stacks empty, every slot free, no clearing pass
module multi_stack_shared_store #(
   parameter int CAPACITY   = 16,
   parameter int NUM_STACKS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_mode,
   input  logic [1:0]         req_stack_sel,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_pop_value,
   output logic [1:0]         rsp_status
);

   localparam int IW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   function automatic logic [SW-1:0] fold_sel(input logic [1:0] sel);
      logic [2:0] v;
      v = {1'b0, sel};
      for (int k = 0; k < 4; k++) begin
         if (int'(v) >= NUM_STACKS) begin
            v = v - 3'(NUM_STACKS);
         end
      end
      return SW'(v);
   endfunction

   state_type            state_ff;
   logic                 op_pop_ff;
   logic                 err_ff;
   logic [SW-1:0]        sel_ff;
   logic [IW-1:0]        slot_ff;
   logic [LW-1:0]        heads_ff [NUM_STACKS];
   logic [LW-1:0]        free_head_ff;
   logic signed [31:0]   value_mem [CAPACITY];
   logic signed [31:0]   value_q_ff;
   logic                 rsp_valid_ff;
   logic signed [31:0]   rsp_pop_value_ff;
   logic [1:0]           rsp_status_ff;

   logic                 accept;
   logic [SW-1:0]        sel_now;
   logic [LW-1:0]        slot_link;
   logic [IW-1:0]        slot_now;
   logic                 err_now;
   logic                 exec_ok;
   logic [LW-1:0]        link_rd;
   logic [LW-1:0]        link_wr;

   assign accept    = start && (state_ff == ST_IDLE);
   assign sel_now   = fold_sel(req_stack_sel);
   assign slot_link = (req_mode == msss_pkg::MODE_POP) ? heads_ff[sel_now] : free_head_ff;
   assign slot_now  = slot_link[IW-1:0];
   assign err_now   = (slot_link >= NULL_LINK);
   assign exec_ok   = (state_ff == ST_EXEC) && !err_ff;
   assign link_wr   = op_pop_ff ? free_head_ff : heads_ff[sel_ff];

   msss_link_mem #(
      .CAPACITY (CAPACITY)
   ) u_link_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && !err_now),
      .rd_addr (slot_now),
      .rd_data (link_rd),
      .wr_en   (exec_ok),
      .wr_addr (slot_ff),
      .wr_data (link_wr)
   );

   // value store: push writes, pop reads, both at the accepting edge
   always_ff @(posedge clock) begin
      if (accept && !err_now) begin
         if (req_mode == msss_pkg::MODE_PUSH) begin
            value_mem[slot_now] <= req_push_value;
         end else begin
            value_q_ff <= value_mem[slot_now];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_STACKS; i++) begin
            heads_ff[i] <= NULL_LINK;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (accept) begin
                  op_pop_ff <= (req_mode == msss_pkg::MODE_POP);
                  err_ff    <= err_now;
                  sel_ff    <= sel_now;
                  slot_ff   <= slot_now;
                  state_ff  <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (!err_ff) begin
                  if (op_pop_ff) begin
                     heads_ff[sel_ff] <= link_rd;
                     free_head_ff     <= LW'(slot_ff);
                  end else begin
                     heads_ff[sel_ff] <= LW'(slot_ff);
                     free_head_ff     <= link_rd;
                  end
               end
               rsp_valid_ff     <= 1'b1;
               rsp_pop_value_ff <= (!err_ff && op_pop_ff) ? value_q_ff : 32'sd0;
               if (!err_ff) begin
                  rsp_status_ff <= msss_pkg::STATUS_OK;
               end else if (op_pop_ff) begin
                  rsp_status_ff <= msss_pkg::STATUS_EMPTY;
               end else begin
                  rsp_status_ff <= msss_pkg::STATUS_FULL;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy          = (state_ff == ST_EXEC);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = rsp_pop_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

>>> hw/rtl/msss_checker.sv
// ----------------------------------------------------------------------------
// msss_checker
// port-level checks of the shared-store stack block, bound to the top level
// ----------------------------------------------------------------------------
`include "multi_stack_shared_store_macros.svh"

module msss_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_mode,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_pop_value,
   input logic [1:0]         rsp_status
);

   `MSSS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "request not taken")
   `MSSS_ASSERT_NEXT(a_busy_response, clock, reset, busy, rsp_valid && !busy, "no response")
   `MSSS_ASSERT_NOW(a_error_zero, clock, reset,
      rsp_valid && (rsp_status != msss_pkg::STATUS_OK),
      rsp_pop_value == 32'sd0, "error value not zero")
   `MSSS_ASSERT_NOW(a_full_on_push, clock, reset,
      rsp_valid && (rsp_status == msss_pkg::STATUS_FULL),
      $past(req_mode, 2) == msss_pkg::MODE_PUSH, "full status on pop")

endmodule

bind multi_stack_shared_store msss_checker u_msss_checker (.*);

>>> dv/multi_stack_shared_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stack_shared_store_tb
// drives push and pop requests into the shared-store stack block, keeps its
// own model of the free list, link chains and stack tops, and checks every
// result strobe in order against the model; a short directed sequence covers
// empty pops, extreme values and a full store, then random bursts with a
// drifting push/pop mix fill and drain the store again and again
// ----------------------------------------------------------------------------
module multi_stack_shared_store_tb;

   localparam int CAPACITY    = 16;
   localparam int NUM_STACKS  = 4;
   localparam int LINK_W      = $clog2(CAPACITY + 1);
   localparam int DIRECTED_N  = 25;
   localparam int RANDOM_N    = 975;
   localparam int QUIET_LIMIT = 400;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

   localparam logic       MODE_PUSH    = msss_pkg::MODE_PUSH;
   localparam logic       MODE_POP     = msss_pkg::MODE_POP;
   localparam logic [1:0] STATUS_OK    = msss_pkg::STATUS_OK;
   localparam logic [1:0] STATUS_FULL  = msss_pkg::STATUS_FULL;
   localparam logic [1:0] STATUS_EMPTY = msss_pkg::STATUS_EMPTY;

   typedef struct packed {
      logic               mode;
      logic [1:0]         sel;
      logic signed [31:0] value;
      logic               known;
      logic signed [31:0] exp_pop;
      logic [1:0]         exp_status;
   } stack_req_type;

   typedef struct packed {
      logic signed [31:0] pop_value;
      logic [1:0]         status;
   } pop_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_mode = MODE_PUSH;
   logic [1:0]         req_stack_sel = 2'd0;
   logic signed [31:0] req_push_value = 32'sd0;
   logic               rsp_valid;
   logic signed [31:0] rsp_pop_value;
   logic [1:0]         rsp_status;

   logic               drv_known = 1'b0;
   logic signed [31:0] drv_exp_pop = 32'sd0;
   logic [1:0]         drv_exp_status = STATUS_OK;

   logic signed [31:0] value_mem [CAPACITY];
   logic [LINK_W-1:0]  link_mem [CAPACITY];
   logic [LINK_W-1:0]  stack_top [NUM_STACKS];
   logic [LINK_W-1:0]  free_head;

   pop_result_type expected_pops [$];
   int             mismatch_count = 0;
   int             quiet_cycles = 0;
   stack_req_type  directed_reqs [DIRECTED_N];

   multi_stack_shared_store #(
      .CAPACITY   (CAPACITY),
      .NUM_STACKS (NUM_STACKS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_stack_sel  (req_stack_sel),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status)
   );

   always #4 clock = ~clock;

   task automatic reset_stack_model();
      for (int i = 0; i < CAPACITY; i++) begin
         value_mem[i] = 32'sd0;
         link_mem[i]  = (i + 1 < CAPACITY) ? LINK_W'(i + 1) : NULL_LINK;
      end
      for (int s = 0; s < NUM_STACKS; s++) stack_top[s] = NULL_LINK;
      free_head = '0;
   endtask

   task automatic predict_stack_op(input logic mode, input logic [1:0] sel,
                                   input logic signed [31:0] value,
                                   output pop_result_type res);
      logic [LINK_W-1:0] slot;
      int                s;
      s = int'(sel) % NUM_STACKS;
      res.pop_value = 32'sd0;
      res.status    = STATUS_OK;
      if (mode == MODE_PUSH) begin
         if (free_head >= NULL_LINK) begin
            res.status = STATUS_FULL;
         end else begin
            slot            = free_head;
            value_mem[slot] = value;
            free_head       = link_mem[slot];
            link_mem[slot]  = stack_top[s];
            stack_top[s]    = slot;
         end
      end else begin
         if (stack_top[s] >= NULL_LINK) begin
            res.status = STATUS_EMPTY;
         end else begin
            slot          = stack_top[s];
            stack_top[s]  = link_mem[slot];
            res.pop_value = value_mem[slot];
            link_mem[slot] = free_head;
            free_head     = slot;
         end
      end
   endtask

   // request capture and result check, both at the rising edge
   always @(posedge clock) begin : monitor
      pop_result_type predicted;
      pop_result_type want;
      logic           accepted;
      accepted = start && !busy;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (accepted) begin
            predict_stack_op(req_mode, req_stack_sel, req_push_value, predicted);
            if (drv_known) begin
               want.pop_value = drv_exp_pop;
               want.status    = drv_exp_status;
            end else begin
               want = predicted;
            end
            expected_pops.push_back(want);
         end
         if (rsp_valid) begin
            if (expected_pops.size() == 0) begin
               $display("%0t: result with no request waiting, pop_value %0d status %0d",
                        $time, rsp_pop_value, rsp_status);
               mismatch_count++;
            end else begin
               want = expected_pops.pop_front();
               if (rsp_pop_value !== want.pop_value) begin
                  $display("%0t: pop_value expected %0d actual %0d",
                           $time, want.pop_value, rsp_pop_value);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         quiet_cycles <= (accepted || rsp_valid) ? 0 : quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("multi_stack_shared_store: mismatch");
      $finish;
   end

   // entered and left at a falling edge
   task automatic drive_request(input stack_req_type rq, input bit may_idle);
      if (may_idle && $urandom_range(0, 99) < 18) begin
         start = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      start          = 1'b1;
      req_mode       = rq.mode;
      req_stack_sel  = rq.sel;
      req_push_value = rq.value;
      drv_known      = rq.known;
      drv_exp_pop    = rq.exp_pop;
      drv_exp_status = rq.exp_status;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      start = 1'b0;
      while (expected_pops.size() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      stack_req_type rq;
      int            push_bias;
      directed_reqs = '{
         '{MODE_POP,  2'd0, 32'sd0,        1'b1, 32'sd0,        STATUS_EMPTY},
         '{MODE_POP,  2'd3, 32'sd0,        1'b1, 32'sd0,        STATUS_EMPTY},
         '{MODE_PUSH, 2'd0, 32'h7FFF_FFFF, 1'b1, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd1, 32'h8000_0000, 1'b1, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd3, 32'hFFFF_FFFF, 1'b1, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd2, 32'h0000_0000, 1'b1, 32'sd0,        STATUS_OK},
         '{MODE_POP,  2'd1, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, STATUS_OK},
         '{MODE_POP,  2'd0, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, STATUS_OK},
         '{MODE_POP,  2'd0, 32'sd0,        1'b1, 32'sd0,        STATUS_EMPTY},
         '{MODE_PUSH, 2'd0, 32'h0000_0001, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd1, 32'hFFFF_FFFE, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd2, 32'hAAAA_AAAA, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd3, 32'h5555_5555, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd0, 32'h1234_5678, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd1, 32'hEDCB_A987, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd2, 32'h0F0F_0F0F, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd3, 32'hF0F0_F0F0, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd3, 32'h00FF_00FF, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd3, 32'hFF00_FF00, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd0, 32'h8000_0001, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd1, 32'h7FFF_FFFE, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd2, 32'hDEAD_0001, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd3, 32'h0000_FFFF, 1'b0, 32'sd0,        STATUS_OK},
         '{MODE_PUSH, 2'd1, 32'h1357_9BDF, 1'b1, 32'sd0,        STATUS_FULL},
         '{MODE_POP,  2'd3, 32'hFFFF_0000, 1'b0, 32'sd0,        STATUS_OK}
      };
      reset_stack_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIRECTED_N; i++) drive_request(directed_reqs[i], 1'b1);
      drain_results();

      // bursts that lean toward push or pop so the store fills and empties
      push_bias = 50;
      for (int n = 0; n < RANDOM_N; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: push_bias = 85;
               1: push_bias = 50;
               default: push_bias = 15;
            endcase
         end
         if (n == RANDOM_N / 2) drain_results();
         rq.mode       = ($urandom_range(0, 99) < push_bias) ? MODE_PUSH : MODE_POP;
         rq.sel        = 2'($urandom_range(0, 3));
         rq.value      = $urandom;
         rq.known      = 1'b0;
         rq.exp_pop    = 32'sd0;
         rq.exp_status = STATUS_OK;
         drive_request(rq, !(n >= 300 && n < 480));
      end

      drain_results();
      repeat (6) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("multi_stack_shared_store: match");
      end else begin
         $display("multi_stack_shared_store: mismatch");
      end
      $finish;
   end

endmodule

>>> multi_stack_shared_store.f
+incdir+hw/rtl
hw/rtl/msss_pkg.sv
hw/rtl/msss_link_mem.sv
hw/rtl/multi_stack_shared_store.sv
hw/rtl/msss_checker.sv
dv/multi_stack_shared_store_tb.sv
